// File: hdl/depth_haze_frame_blend_defines.svh
// Assertion helpers for the control RTL file
`ifndef DEPTH_HAZE_FRAME_BLEND_DEFINES_SVH
`define DEPTH_HAZE_FRAME_BLEND_DEFINES_SVH

// Checked only outside reset
`define DHFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define DHFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/dhfb_pkg.sv
package dhfb_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HAZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_R   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_G   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_B   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd6;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic        hit;
    logic [31:0] depth;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit_out;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } res_t;

  typedef struct packed {
    logic       capture;
    logic       wr;
    logic       clr;
    logic       load;
    logic       mul;
    logic       div_go;
    logic       coef;
    logic       blend;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_frame;
    logic       blend_need;
    logic       div_busy;
  } sts_t;

endpackage

// File: hdl/dhfb_div.sv
module dhfb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [50:0] num_i,
  input  logic [30:0]        den_i,
  output logic               busy_o,
  output logic signed [19:0] quo_o
);
  import dhfb_pkg::*;

  localparam int QBITS = 18;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [30:0] rem_q, rem_d;
  logic [QBITS-1:0] low_q, low_d;
  logic [QBITS-1:0] quo_q, quo_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;

  logic [50:0] mag;
  logic [32:0] hi;
  logic [31:0] trial;
  logic [18:0] qmag;

  always_comb begin
    mag    = num_i[50] ? 51'(-num_i) : 51'(num_i);
    hi     = mag[50:QBITS];
    trial  = {rem_q, low_q[QBITS-1]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(QBITS);
      neg_d  = num_i[50];
      ovf_d  = hi >= {2'b00, den_i};
      rem_d  = hi[30:0];
      low_d  = mag[QBITS-1:0];
      quo_d  = '0;
    end else if (busy_q) begin
      // one restoring step per cycle
      if (trial >= {1'b0, den_i}) begin
        rem_d = 31'(trial - {1'b0, den_i});
        quo_d = {quo_q[QBITS-2:0], 1'b1};
      end else begin
        rem_d = trial[30:0];
        quo_d = {quo_q[QBITS-2:0], 1'b0};
      end
      low_d = {low_q[QBITS-2:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  // floor rounding for negative numerators; saturate huge quotients
  always_comb begin
    if (ovf_q) qmag = 19'h40000;
    else qmag = {1'b0, quo_q} + 19'((neg_q && (rem_q != '0)) ? 1 : 0);
    quo_o = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  assign busy_o = busy_q;

endmodule

// File: hdl/dhfb_datapath.sv
module dhfb_datapath #(
  parameter int MAX_WIDTH  = dhfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dhfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dhfb_pkg::cmd_t                 cmd_i,
  output dhfb_pkg::sts_t                 sts_o,
  input  dhfb_pkg::req_t                 req_i,
  output dhfb_pkg::res_t                 res_o,
  input  logic                           cfg_we_i,
  input  logic [dhfb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dhfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dhfb_pkg::*;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef struct packed {
    logic        hit;
    logic [31:0] depth;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pix_t;

  // configuration
  logic [16:0] haze_q;
  logic [15:0] bg_q [3];
  logic        std_q;
  logic [9:0]  fw_q, fh_q;

  // depth extremes
  logic signed [31:0] near_q, far_q;
  logic               ext_valid_q;

  req_t               req_q;
  pix_t               mem_q [MEM_DEPTH];
  pix_t               rd_q;
  logic               hit_q;
  logic signed [31:0] dep_q;
  logic [15:0]        chan_q [3];
  logic signed [50:0] num_q;
  logic [16:0]        coef_q;

  logic [ADDR_W-1:0]  addr;
  logic               in_frame;
  logic [16:0]        h_sat;
  logic [30:0]        span;
  logic               div_busy;
  logic signed [19:0] quo;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [20:0] csum;
  logic [15:0]        c_sel, bg_sel;
  logic signed [16:0] cdiff;
  logic signed [34:0] cprod;
  logic signed [35:0] acc;
  logic [19:0]        vout;
  logic signed [31:0] d_in;

  assign in_frame = (int'(req_q.pos_x) < int'(fw_q)) && (int'(req_q.pos_y) < int'(fh_q)) &&
                    (int'(req_q.pos_x) < MAX_WIDTH) && (int'(req_q.pos_y) < MAX_HEIGHT);
  assign addr   = ADDR_W'(32'(req_q.pos_y) * 32'(MAX_WIDTH) + 32'(req_q.pos_x));
  assign h_sat  = (haze_q > ONE_Q16) ? ONE_Q16 : haze_q;
  assign span   = 31'(far_q - near_q);
  assign d_in   = $signed(req_q.depth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      haze_q <= '0;
      bg_q   <= '{default: '0};
      std_q  <= 1'b1;
      fw_q   <= 10'd512;
      fh_q   <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HAZE:   haze_q   <= cfg_data_i;
        CFG_BG_R:   bg_q[0]  <= cfg_data_i[15:0];
        CFG_BG_G:   bg_q[1]  <= cfg_data_i[15:0];
        CFG_BG_B:   bg_q[2]  <= cfg_data_i[15:0];
        CFG_STD:    std_q    <= cfg_data_i[0];
        CFG_WIDTH:  fw_q     <= cfg_data_i[9:0];
        CFG_HEIGHT: fh_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q      <= '0;
      far_q       <= '0;
      ext_valid_q <= 1'b0;
    end else if (cmd_i.clr) begin
      near_q      <= '0;
      far_q       <= '0;
      ext_valid_q <= 1'b0;
    end else if (cmd_i.wr && (d_in > 0)) begin
      if (!ext_valid_q) begin
        near_q      <= d_in;
        far_q       <= d_in;
        ext_valid_q <= 1'b1;
      end else begin
        if (d_in < near_q) near_q <= d_in;
        if (d_in > far_q)  far_q  <= d_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem_q[addr] <= '{hit: req_q.hit, depth: req_q.depth, red: req_q.red_in,
                                   green: req_q.green_in, blue: req_q.blue_in};
    rd_q <= mem_q[addr];
  end

  assign diff = 33'(far_q) - 33'(dep_q);
  assign prod = $signed({1'b0, h_sat}) * diff;
  assign csum = $signed({4'b0, 17'(ONE_Q16 - h_sat)}) + 21'(quo);

  always_comb begin
    case (cmd_i.ch)
      CH_RED:   begin c_sel = chan_q[0]; bg_sel = bg_q[0]; end
      CH_GREEN: begin c_sel = chan_q[1]; bg_sel = bg_q[1]; end
      default:  begin c_sel = chan_q[2]; bg_sel = bg_q[2]; end
    endcase
    cdiff = $signed({1'b0, c_sel}) - $signed({1'b0, bg_sel});
    cprod = cdiff * $signed({1'b0, coef_q});
    acc   = $signed({4'b0, bg_sel, 16'b0}) + 36'(cprod) + 36'sd32768;
    vout  = acc[35:16];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_q     <= rd_q.hit;
      dep_q     <= $signed(rd_q.depth);
      chan_q[0] <= rd_q.red;
      chan_q[1] <= rd_q.green;
      chan_q[2] <= rd_q.blue;
    end else if (cmd_i.blend) begin
      case (cmd_i.ch)
        CH_RED:   chan_q[0] <= (vout > 20'd65535) ? 16'hFFFF : vout[15:0];
        CH_GREEN: chan_q[1] <= (vout > 20'd65535) ? 16'hFFFF : vout[15:0];
        default:  chan_q[2] <= (vout > 20'd65535) ? 16'hFFFF : vout[15:0];
      endcase
    end
    if (cmd_i.mul) num_q <= prod;
    if (cmd_i.coef) begin
      if (csum < 0) coef_q <= '0;
      else if (csum > 21'sd65536) coef_q <= ONE_Q16;
      else coef_q <= csum[16:0];
    end
  end

  dhfb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (num_q),
    .den_i   (span),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign sts_o.op         = req_q.opcode;
  assign sts_o.in_frame   = in_frame;
  assign sts_o.blend_need = rd_q.hit && std_q && (far_q != near_q);
  assign sts_o.div_busy   = div_busy;

  always_comb begin
    res_o = '0;
    if (req_q.opcode == OP_STORE || req_q.opcode == OP_READ) begin
      if (!in_frame) begin
        res_o.status = 1'b1;
      end else if (req_q.opcode == OP_READ) begin
        res_o.hit_out   = hit_q;
        res_o.red_out   = chan_q[0];
        res_o.green_out = chan_q[1];
        res_o.blue_out  = chan_q[2];
      end
    end
  end

endmodule

// File: hdl/dhfb_ctrl.sv
`include "depth_haze_frame_blend_defines.svh"

module dhfb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  output dhfb_pkg::cmd_t cmd_o,
  input  dhfb_pkg::sts_t sts_i
);
  import dhfb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_LOAD, ST_MUL, ST_DIVGO, ST_DIV, ST_COEF,
    ST_BL_R, ST_BL_G, ST_BL_B, ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic       busy_q, done_q;
  logic       accept;
  logic [6:0] cmd_vec;

  assign accept = start && !busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.capture = accept;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_DECODE;
      ST_DECODE: begin
        state_d = ST_FINISH;
        if (sts_i.op == OP_CLEAR) begin
          cmd_o.clr = 1'b1;
        end else if (sts_i.in_frame && sts_i.op == OP_STORE) begin
          cmd_o.wr = 1'b1;
        end else if (sts_i.in_frame && sts_i.op == OP_READ) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.blend_need ? ST_MUL : ST_FINISH;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV:    if (!sts_i.div_busy) state_d = ST_COEF;
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        state_d    = ST_BL_R;
      end
      ST_BL_R: begin
        cmd_o.blend = 1'b1;
        cmd_o.ch    = CH_RED;
        state_d     = ST_BL_G;
      end
      ST_BL_G: begin
        cmd_o.blend = 1'b1;
        cmd_o.ch    = CH_GREEN;
        state_d     = ST_BL_B;
      end
      ST_BL_B: begin
        cmd_o.blend = 1'b1;
        cmd_o.ch    = CH_BLUE;
        state_d     = ST_FINISH;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      done_q  <= (state_d == ST_FINISH);
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

  assign cmd_vec = {cmd_o.wr, cmd_o.clr, cmd_o.load, cmd_o.mul, cmd_o.div_go, cmd_o.coef,
                    cmd_o.blend};

  `DHFB_ASSERT(a_accept_busy, accept |=> busy_q, "accepted request did not raise busy")
  `DHFB_ASSERT(a_done_single, done_q |=> (!done_q && !busy_q), "result strobe not single")
  `DHFB_ASSERT(a_cmd_onehot, $onehot0(cmd_vec), "overlapping datapath commands")
  `DHFB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!busy_q && !done_q), "control active in reset")

endmodule

// File: hdl/depth_haze_frame_blend.sv
// Frame store with depth haze: one request at a time. A request is taken when start is high
// and busy is low; its result appears on res_o for exactly one cycle with done_o high, and
// the receiver cannot hold it off. A store, a clear, an unused opcode or an out-of-frame
// coordinate passes through decode and finish; a read that needs no blend adds a load; a
// blended read goes load, multiply, divider start, a wait on the 18-step restoring divider
// for the depth span, a clamp to the coefficient and three channel blends that share one
// multiplier, then finish. busy drops in the cycle after done_o, and the next request can be
// taken no earlier. Pixel memory is not cleared; read only pixels that were stored.
module depth_haze_frame_blend #(
  parameter int MAX_WIDTH  = dhfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dhfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dhfb_pkg::req_t                  req_i,
  output logic                            done_o,
  output dhfb_pkg::res_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [dhfb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dhfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dhfb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dhfb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  dhfb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (req_i),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

// File: dv/depth_haze_frame_blend_tb.sv
`timescale 1ns / 1ps

module depth_haze_frame_blend_tb;
  import dhfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  class haze_scoreboard;
    res_t        pending_q[$];
    int          fail_cnt;
    // predictor state
    logic [47:0] pix_color[int];
    logic [32:0] pix_depth[int];
    longint      nearest;
    longint      farthest;
    bit          extremes_ok;
    logic [16:0] haze;
    logic [15:0] bg_r, bg_g, bg_b;
    bit          std_mode;
    int          fr_w, fr_h;

    function new();
      fail_cnt = 0;
      nearest = 0;
      farthest = 0;
      extremes_ok = 0;
      haze = 0;
      bg_r = 0;
      bg_g = 0;
      bg_b = 0;
      std_mode = 1;
      fr_w = 512;
      fr_h = 512;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HAZE:   haze = val;
        CFG_BG_R:   bg_r = val[15:0];
        CFG_BG_G:   bg_g = val[15:0];
        CFG_BG_B:   bg_b = val[15:0];
        CFG_STD:    std_mode = val[0];
        CFG_WIDTH:  fr_w = int'(val[9:0]);
        CFG_HEIGHT: fr_h = int'(val[9:0]);
        default: ;
      endcase
    endfunction

    function logic [15:0] mix_chan(logic [15:0] c, logic [15:0] bg, longint coef);
      longint v;
      v = (longint'(c) * coef + longint'(bg) * (65536 - coef) + 32768) >>> 16;
      return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function bit in_frame(int x, int y);
      return x < fr_w && y < fr_h && x < DEF_MAX_WIDTH && y < DEF_MAX_HEIGHT;
    endfunction

    function void note_request(req_t rq);
      res_t   r;
      int     idx;
      longint d, h, span, num, q, coef;
      logic [47:0] col;
      logic [32:0] ds;
      r = '0;
      idx = rq.pos_y * DEF_MAX_WIDTH + rq.pos_x;
      if (rq.opcode == OP_CLEAR) begin
        nearest = 0;
        farthest = 0;
        extremes_ok = 0;
      end else if (rq.opcode == OP_STORE || rq.opcode == OP_READ) begin
        if (!in_frame(rq.pos_x, rq.pos_y)) begin
          r.status = 1'b1;
        end else if (rq.opcode == OP_STORE) begin
          pix_color[idx] = {rq.red_in, rq.green_in, rq.blue_in};
          pix_depth[idx] = {rq.hit, rq.depth};
          d = longint'($signed(rq.depth));
          if (d > 0) begin
            if (!extremes_ok) begin
              nearest = d;
              farthest = d;
              extremes_ok = 1;
            end else begin
              if (d < nearest) nearest = d;
              if (d > farthest) farthest = d;
            end
          end
        end else begin
          col = pix_color.exists(idx) ? pix_color[idx] : '0;
          ds = pix_depth.exists(idx) ? pix_depth[idx] : '0;
          r.hit_out = ds[32];
          r.red_out = col[47:32];
          r.green_out = col[31:16];
          r.blue_out = col[15:0];
          if (ds[32] && std_mode) begin
            d = longint'($signed(ds[31:0]));
            h = (haze > 17'd65536) ? 65536 : longint'(haze);
            span = farthest - nearest;
            coef = 65536;
            if (span > 0) begin
              num = h * (farthest - d);
              q = (num >= 0) ? num / span : -((-num + span - 1) / span);
              coef = (65536 - h) + q;
              if (coef < 0) coef = 0;
              if (coef > 65536) coef = 65536;
            end
            r.red_out = mix_chan(col[47:32], bg_r, coef);
            r.green_out = mix_chan(col[31:16], bg_g, coef);
            r.blue_out = mix_chan(col[15:0], bg_b, coef);
          end
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        fail_cnt++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d actual %0d", exp_r.status, got.status);
        fail_cnt++;
      end
      if (got.hit_out !== exp_r.hit_out) begin
        $error("hit_out: expected %0d actual %0d", exp_r.hit_out, got.hit_out);
        fail_cnt++;
      end
      if (got.red_out !== exp_r.red_out) begin
        $error("red_out: expected %h actual %h", exp_r.red_out, got.red_out);
        fail_cnt++;
      end
      if (got.green_out !== exp_r.green_out) begin
        $error("green_out: expected %h actual %h", exp_r.green_out, got.green_out);
        fail_cnt++;
      end
      if (got.blue_out !== exp_r.blue_out) begin
        $error("blue_out: expected %h actual %h", exp_r.blue_out, got.blue_out);
        fail_cnt++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  haze_scoreboard sb;
  int  idle_pct;
  int  stall_cycles;
  // pixels written per frame setting, so reads never hit an unwritten pixel
  int  written_x[$];
  int  written_y[$];

  depth_haze_frame_blend u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // check results and keep the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if ((start && !busy) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // hold start high across back-to-back requests; drop it only while idling
  task automatic send_request(req_t rq);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(rq);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, CFG_DATA_W'(val));
  endtask

  function automatic req_t make_req(logic [1:0] op, int x, int y, int h, logic [31:0] d,
                                    int r, int g, int b);
    req_t rq;
    rq.opcode = op;
    rq.pos_x = 9'(x);
    rq.pos_y = 9'(y);
    rq.hit = 1'(h);
    rq.depth = d;
    rq.red_in = 16'(r);
    rq.green_in = 16'(g);
    rq.blue_in = 16'(b);
    return rq;
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h0000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom_range(32'h0040_0000, 1);
    endcase
  endfunction

  task automatic store_pixel(int x, int y, bit h, logic [31:0] d);
    send_request(make_req(OP_STORE, x, y, h, d, $urandom(), $urandom(), $urandom()));
    if (sb.in_frame(x, y)) begin
      written_x.push_back(x);
      written_y.push_back(y);
    end
  endtask

  // mostly small frames so stores and reads land on the same pixels
  task automatic random_phase(int n_items);
    int k, x, y, sel;
    req_t rq;
    for (k = 0; k < n_items; k++) begin
      sel = $urandom_range(99);
      if (sel < 40 || written_x.size() == 0) begin
        x = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(sb.fr_w);
        y = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(sb.fr_h);
        store_pixel(x, y, $urandom_range(3) != 0, rand_depth());
      end else if (sel < 90) begin
        sel = $urandom_range(written_x.size() - 1);
        send_request(make_req(OP_READ, written_x[sel], written_y[sel], $urandom_range(1),
                              $urandom(), $urandom(), $urandom(), $urandom()));
      end else if (sel < 94) begin
        // out-of-frame read
        x = $urandom_range(511);
        y = $urandom_range(511);
        if (sb.in_frame(x, y)) x = 511;
        if (sb.in_frame(x, y)) y = 511;
        rq = make_req(OP_READ, x, y, 0, 0, 0, 0, 0);
        if (!sb.in_frame(x, y)) send_request(rq);
      end else if (sel < 97) begin
        send_request(make_req(OP_CLEAR, $urandom(), $urandom(), $urandom_range(1),
                              $urandom(), $urandom(), $urandom(), $urandom()));
      end else begin
        send_request(make_req(2'd3, $urandom(), $urandom(), $urandom_range(1),
                              $urandom(), $urandom(), $urandom(), $urandom()));
      end
    end
  endtask

  task automatic new_setting(int w, int h_rows, int hz, bit std_on);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h_rows);
    write_reg(CFG_HAZE, hz);
    write_reg(CFG_BG_R, $urandom());
    write_reg(CFG_BG_G, $urandom());
    write_reg(CFG_BG_B, $urandom());
    write_reg(CFG_STD, std_on);
    written_x.delete();
    written_y.delete();
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, special cases, default config
    store_pixel(0, 0, 1, 32'h0001_0000);
    store_pixel(511, 511, 1, 32'h7FFF_FFFF);
    store_pixel(5, 7, 1, 32'h8000_0000);
    store_pixel(6, 7, 0, 32'h0000_0000);
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 511, 511, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 5, 7, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 6, 7, 0, 0, 0, 0, 0));
    send_request(make_req(2'd3, 3, 3, 1, 32'hFFFF_FFFF, '1, '1, '1));
    send_request(make_req(OP_CLEAR, 511, 511, 1, '1, '1, '1, '1));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    new_setting(512, 512, 17'h10000, 1);
    write_reg(CFG_BG_R, 16'hFFFF);
    write_reg(CFG_BG_G, 16'h0000);
    write_reg(CFG_BG_B, 16'hFFFF);
    store_pixel(1, 1, 1, 32'h0000_0001);
    store_pixel(2, 1, 1, 32'h0100_0000);
    store_pixel(3, 1, 1, 32'h0080_0000);
    send_request(make_req(OP_READ, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 2, 1, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 3, 1, 0, 0, 0, 0, 0));
    new_setting(1, 1, 17'h1FFFF, 1);
    store_pixel(0, 0, 1, 32'h0000_0100);
    send_request(make_req(OP_READ, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_STORE, 0, 1, 1, 5, 1, 1, 1));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));

    // random: sender idle profiles, varying settings
    idle_pct = 26;
    new_setting(8, 6, $urandom_range(65536), 1);
    random_phase(200);
    new_setting(16, 16, 17'h00000, 1);
    random_phase(150);
    idle_pct = 84;
    new_setting(4, 12, 17'h08000, 1);
    random_phase(150);
    new_setting(512, 512, 17'h10000, 0);
    random_phase(100);
    idle_pct = 0;
    new_setting(10, 3, $urandom_range(65536), 1);
    random_phase(250);
    new_setting(1, 512, 17'h1FFFF, 1);
    random_phase(100);
    new_setting(6, 6, $urandom_range(65536), 1);
    random_phase(300);

    wait_idle();
    if (sb.fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
